@@ rtl/srp_pkg.sv @@
// shared types and constants of the servo ramp interpolator
// no dependencies; every other file imports this package
package srp_pkg;

    localparam int CHANNELS_DEF     = 24;
    localparam int RAMP_STEPS_DEF   = 10;
    localparam int MAX_POSITION_DEF = 250;

    localparam int CH_W  = 5;
    localparam int POS_W = 8;
    localparam int IDX_W = 4;

    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic              command;
        logic [CH_W-1:0]   channel;
        logic [POS_W-1:0]  target;
        logic signed [7:0] trim;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [POS_W-1:0] position;
        logic [IDX_W-1:0] step_index;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic             en;
        logic [CH_W-1:0]  addr;
        logic [POS_W-1:0] data;
    } pos_wr_t;

    typedef struct packed {
        logic             command;
        logic [CH_W-1:0]  channel;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] quo;
        logic [3:0]       rem;
        dir_t             dir;
    } ramp_load_t;

endpackage

@@ rtl/srp_pos_store.sv @@
// per-channel position memory, registered read
// forwards a write landing in the read cycle; valid bits give reset-to-zero
// depends on srp_pkg
module srp_pos_store
    import srp_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [CH_W-1:0]  rd_addr,
    input  pos_wr_t          wr,
    output logic [POS_W-1:0] rd_data
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [POS_W-1:0]    mem [CHANNELS];
    logic [POS_W-1:0]    mem_q_reg;
    logic [POS_W-1:0]    fwd_data_reg;
    logic [CHANNELS-1:0] vld_reg, vld_next;
    logic                fwd_reg, fwd_next;
    logic                entry_vld_reg, entry_vld_next;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[ADDR_W-1:0]] <= wr.data;
        end
        if (rd_en) begin
            mem_q_reg    <= mem[rd_addr[ADDR_W-1:0]];
            fwd_data_reg <= wr.data;
        end
    end

    always_comb begin
        vld_next       = vld_reg;
        fwd_next       = fwd_reg;
        entry_vld_next = entry_vld_reg;
        if (wr.en) begin
            vld_next[wr.addr[ADDR_W-1:0]] = 1'b1;
        end
        if (rd_en) begin
            fwd_next       = wr.en && (wr.addr == rd_addr);
            entry_vld_next = vld_reg[rd_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            fwd_reg       <= 1'b0;
            entry_vld_reg <= 1'b0;
        end else begin
            vld_reg       <= vld_next;
            fwd_reg       <= fwd_next;
            entry_vld_reg <= entry_vld_next;
        end
    end

    assign rd_data = fwd_reg       ? fwd_data_reg :
                     entry_vld_reg ? mem_q_reg    : '0;

endmodule

@@ rtl/srp_ramp_calc.sv @@
// goal clamp, distance and divide-by-steps pipeline (two stages)
// writes the final position back to the store as the item leaves stage one
// depends on srp_pkg
module srp_ramp_calc
    import srp_pkg::*;
#(
    parameter int RAMP_STEPS   = RAMP_STEPS_DEF,
    parameter int MAX_POSITION = MAX_POSITION_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  in_item_t         item,
    input  logic [POS_W-1:0] cur_pos,
    input  logic             seq_free,
    output logic             ready,
    output pos_wr_t          wr,
    output logic             load_valid,
    output ramp_load_t       load
);

    localparam int               RECIP_SH = 16;
    localparam int               RECIP    = (1 << RECIP_SH) / RAMP_STEPS;
    localparam logic [16:0]      RECIP_K  = 17'(RECIP);
    localparam logic [4:0]       STEPS_K  = 5'(RAMP_STEPS);
    localparam logic signed [9:0] MAX_K   = 10'(MAX_POSITION);

    // stage one
    logic              b_vld_reg, b_vld_next;
    in_item_t          b_item_reg;
    logic signed [9:0] sum;
    logic [POS_W-1:0]  goal;
    logic [POS_W-1:0]  span;
    dir_t              dir;
    logic [24:0]       prod;
    logic              b_adv;

    // stage two
    logic             c_vld_reg, c_vld_next;
    logic             c_cmd_reg;
    logic [CH_W-1:0]  c_ch_reg;
    logic [POS_W-1:0] c_start_reg;
    logic [POS_W-1:0] c_dist_reg;
    logic [POS_W-1:0] c_q0_reg;
    dir_t             c_dir_reg;
    logic [12:0]      qr;
    logic [POS_W-1:0] r0;
    logic             c_free;

    assign c_free = !c_vld_reg || seq_free;
    assign b_adv  = b_vld_reg && c_free;
    assign ready  = !b_vld_reg || c_free;

    // clamp without byte wrap
    assign sum = $signed({2'b00, b_item_reg.target})
               + $signed({{2{b_item_reg.trim[7]}}, b_item_reg.trim});

    always_comb begin
        if (sum < 10'sd0) begin
            goal = '0;
        end else if (sum > MAX_K) begin
            goal = MAX_K[POS_W-1:0];
        end else begin
            goal = sum[POS_W-1:0];
        end
        if (goal > cur_pos) begin
            dir  = DIR_UP;
            span = goal - cur_pos;
        end else if (goal < cur_pos) begin
            dir  = DIR_DOWN;
            span = cur_pos - goal;
        end else begin
            dir  = DIR_NONE;
            span = '0;
        end
    end

    // quotient estimate by reciprocal, at most one short
    assign prod = 25'(span) * 25'(RECIP_K);

    assign wr.en   = b_adv;
    assign wr.addr = b_item_reg.channel;
    assign wr.data = (b_item_reg.command == CMD_SET) ? b_item_reg.target : goal;

    // remainder correction
    assign qr = 13'(c_q0_reg) * 13'(STEPS_K);
    assign r0 = c_dist_reg - qr[POS_W-1:0];

    always_comb begin
        load.command = c_cmd_reg;
        load.channel = c_ch_reg;
        load.start   = c_start_reg;
        load.dir     = c_dir_reg;
        if (r0 >= 8'(STEPS_K)) begin
            load.quo = c_q0_reg + 8'd1;
            load.rem = 4'(r0 - 8'(STEPS_K));
        end else begin
            load.quo = c_q0_reg;
            load.rem = 4'(r0);
        end
    end

    assign load_valid = c_vld_reg;

    always_comb begin
        b_vld_next = b_vld_reg;
        c_vld_next = c_vld_reg;
        if (take) begin
            b_vld_next = 1'b1;
        end else if (b_adv) begin
            b_vld_next = 1'b0;
        end
        if (b_adv) begin
            c_vld_next = 1'b1;
        end else if (c_vld_reg && seq_free) begin
            c_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            b_vld_reg <= b_vld_next;
            c_vld_reg <= c_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            b_item_reg <= item;
        end
        if (b_adv) begin
            c_cmd_reg   <= b_item_reg.command;
            c_ch_reg    <= b_item_reg.channel;
            c_start_reg <= (b_item_reg.command == CMD_SET) ? b_item_reg.target : cur_pos;
            c_dist_reg  <= span;
            c_q0_reg    <= prod[RECIP_SH +: POS_W];
            c_dir_reg   <= dir;
        end
    end

endmodule

@@ rtl/srp_ramp_seq.sv @@
// ramp sequencer and output register: one position per accepted result
// depends on srp_pkg
module srp_ramp_seq
    import srp_pkg::*;
#(
    parameter int RAMP_STEPS = RAMP_STEPS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load_valid,
    input  ramp_load_t load,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    localparam int               CNT_W  = $clog2(RAMP_STEPS + 1);
    localparam logic [CNT_W-1:0] LAST_K = CNT_W'(RAMP_STEPS);

    logic             vld_reg, vld_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CH_W-1:0]  ch_reg;
    logic [POS_W-1:0] quo_reg;
    dir_t             dir_reg;
    logic             take;
    logic             step;

    assign free = !vld_reg || (m_ready && last_reg);
    assign take = load_valid && free;
    assign step = vld_reg && m_ready && !last_reg;

    always_comb begin
        vld_next  = vld_reg;
        last_next = last_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        if (take) begin
            vld_next = 1'b1;
            cnt_next = '0;
            if (load.command == CMD_SET) begin
                last_next = 1'b1;
                pos_next  = load.start;
            end else begin
                last_next = 1'b0;
                case (load.dir)
                    DIR_UP:   pos_next = load.start + {4'b0000, load.rem};
                    DIR_DOWN: pos_next = load.start - {4'b0000, load.rem};
                    default:  pos_next = load.start;
                endcase
            end
        end else if (step) begin
            cnt_next  = cnt_reg + 1'b1;
            last_next = (cnt_next == LAST_K);
            case (dir_reg)
                DIR_UP:   pos_next = pos_reg + quo_reg;
                DIR_DOWN: pos_next = pos_reg - quo_reg;
                default:  pos_next = pos_reg;
            endcase
        end else if (vld_reg && m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= 1'b0;
            last_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            vld_reg  <= vld_next;
            last_reg <= last_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (take) begin
            ch_reg  <= load.channel;
            quo_reg <= load.quo;
            dir_reg <= load.dir;
        end
    end

    assign m_valid            = vld_reg;
    assign m_data.out_channel = ch_reg;
    assign m_data.position    = pos_reg;
    assign m_data.step_index  = IDX_W'(cnt_reg);
    assign m_data.last        = last_reg;

endmodule

@@ rtl/servo_ramp_interpolator.sv @@
// servo_ramp_interpolator: linear position ramps for a bank of servo channels
// a request's first result passes the first calc stage, the second calc stage and the
//   sequencer's output register; a move yields RAMP_STEPS+1 positions (11 by default),
//   one position per cycle while m_ready holds; a set yields one; requests overlap in the pipe
// reset (aresetn low, synchronous): all stages empty, every channel reads zero
//   through per-channel valid bits, so no clearing pass is needed
module servo_ramp_interpolator
    import srp_pkg::*;
#(
    parameter int CHANNELS     = CHANNELS_DEF,
    parameter int RAMP_STEPS   = RAMP_STEPS_DEF,
    parameter int MAX_POSITION = MAX_POSITION_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam logic [CH_W:0] CH_LIM = (CH_W + 1)'(CHANNELS);

    logic             accept;
    logic             in_range;
    logic             take;
    pos_wr_t          wr;
    logic [POS_W-1:0] cur_pos;
    logic             seq_free;
    logic             load_valid;
    ramp_load_t       load;

    // requests to channels beyond the bank are accepted and dropped
    assign in_range = {1'b0, s_data.channel} < CH_LIM;
    assign accept   = s_valid && s_ready;
    assign take     = accept && in_range;

    // position memory: read issued at acceptance, final position written back
    // when the request leaves the first calc stage
    srp_pos_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (take),
        .rd_addr (s_data.channel),
        .wr      (wr),
        .rd_data (cur_pos)
    );

    // clamp, distance, quotient and remainder
    srp_ramp_calc #(
        .RAMP_STEPS   (RAMP_STEPS),
        .MAX_POSITION (MAX_POSITION)
    ) u_calc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .item       (s_data),
        .cur_pos    (cur_pos),
        .seq_free   (seq_free),
        .ready      (s_ready),
        .wr         (wr),
        .load_valid (load_valid),
        .load       (load)
    );

    // step sequencer doubles as the output register
    srp_ramp_seq #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (load_valid),
        .load       (load),
        .free       (seq_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

@@ rtl/srp_checker.sv @@
// port-level checks of the servo ramp interpolator, bound to the top level
// depends on srp_pkg and servo_ramp_interpolator
module srp_checker
    import srp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no result right after reset
    a_out_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // within a ramp the next position follows at once on the same channel
    a_ramp_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
            m_valid && (m_data.out_channel == $past(m_data.out_channel))
            && (m_data.step_index == IDX_W'($past(m_data.step_index) + 4'd1)))
        else $error("ramp step out of sequence");

endmodule

bind servo_ramp_interpolator srp_checker u_srp_checker (.*);

@@ test/servo_ramp_interpolator_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for servo_ramp_interpolator: directed and random move/set requests
// depends on srp_pkg and the servo_ramp_interpolator rtl; needs no files or arguments
module servo_ramp_interpolator_tb;
    import srp_pkg::*;

    // one queued request plus its sequencing flags
    typedef struct {
        in_item_t req;
        bit       drain;   // hold off until every pending position has come back
        bit       calm;    // from here on no idling on either side
    } pend_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    pend_t        req_backlog[$];
    out_item_t    ramp_expect[$];
    logic [7:0]   servo_pos[CHANNELS_DEF];
    int           fault_count = 0;
    int           send_gap    = 0;
    int           hold_gap    = 0;
    bit           calm_phase  = 1'b0;
    bit           drain_next  = 1'b0;
    bit           gen_calm    = 1'b0;

    servo_ramp_interpolator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predicted positions start at zero, like the store after reset
    initial begin
        for (int i = 0; i < CHANNELS_DEF; i++) servo_pos[i] = '0;
    end

    // work out the positions one accepted request produces and queue them
    function automatic void predict_ramp(in_item_t req);
        int         goal;
        int         span;
        int         quo;
        int         rem;
        int         step;
        logic [7:0] cur;
        dir_t       dir;
        out_item_t  res;
        // channels past the bank are dropped without a result
        if (req.channel >= CHANNELS_DEF) return;
        if (req.command == CMD_SET) begin
            // raw target, no trim and no clamp
            servo_pos[req.channel] = req.target;
            res.out_channel = req.channel;
            res.position    = req.target;
            res.step_index  = '0;
            res.last        = 1'b1;
            ramp_expect.push_back(res);
            return;
        end
        // trimmed goal, clamped rather than wrapped
        goal = int'(req.target) + int'($signed(req.trim));
        if (goal < 0) goal = 0;
        if (goal > MAX_POSITION_DEF) goal = MAX_POSITION_DEF;
        cur = servo_pos[req.channel];
        if (goal > int'(cur)) begin
            dir  = DIR_UP;
            span = goal - int'(cur);
        end else if (goal < int'(cur)) begin
            dir  = DIR_DOWN;
            span = int'(cur) - goal;
        end else begin
            dir  = DIR_NONE;
            span = 0;
        end
        quo = span / RAMP_STEPS_DEF;
        rem = span % RAMP_STEPS_DEF;
        // remainder first, then the equal quotient steps
        for (step = 0; step <= RAMP_STEPS_DEF; step++) begin
            if (dir == DIR_UP)
                cur = cur + 8'((step == 0) ? rem : quo);
            else if (dir == DIR_DOWN)
                cur = cur - 8'((step == 0) ? rem : quo);
            res.out_channel = req.channel;
            res.position    = cur;
            res.step_index  = IDX_W'(step);
            res.last        = (step == RAMP_STEPS_DEF);
            ramp_expect.push_back(res);
        end
        servo_pos[req.channel] = cur;
    endfunction

    // append one request; returns 1 when it addresses a real channel
    function automatic int queue_req(logic cmd, int ch, int tgt, int trm);
        pend_t p;
        p.req.command = cmd;
        p.req.channel = ch[CH_W-1:0];
        p.req.target  = tgt[7:0];
        p.req.trim    = trm[7:0];
        p.drain       = drain_next;
        p.calm        = gen_calm;
        drain_next    = 1'b0;
        req_backlog.push_back(p);
        return (ch < CHANNELS_DEF) ? 1 : 0;
    endfunction

    // trim is zero half of the time, otherwise anywhere in range
    function automatic int rand_trim();
        if ($urandom_range(0, 1) == 0) return 0;
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    // driver: presents the backlog, idles in bursts, predicts on acceptance
    always @(posedge aclk) begin : drive_proc
        logic     v_next;
        in_item_t d_next;
        pend_t    nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            v_next = s_valid;
            d_next = s_data;
            if (s_valid && s_ready) begin
                predict_ramp(s_data);
                v_next = 1'b0;
            end
            if (!v_next && req_backlog.size() != 0) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (req_backlog[0].drain && ramp_expect.size() != 0) begin
                    // pause: let the block drain completely first
                end else if (!calm_phase && !req_backlog[0].calm
                             && $urandom_range(0, 5) == 0) begin
                    // start an idle burst here; send_gap counts down what remains of it
                    send_gap <= $urandom_range(0, 8);
                end else begin
                    nxt = req_backlog.pop_front();
                    if (nxt.calm) calm_phase <= 1'b1;
                    v_next = 1'b1;
                    d_next = nxt.req;
                end
            end
            s_valid <= v_next;
            s_data  <= d_next;
        end
    end

    // monitor: checks every accepted position against the oldest prediction
    always @(posedge aclk) begin : collect_proc
        out_item_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (ramp_expect.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: unexpected result ch=%0d pos=%0d idx=%0d last=%0b",
                                 $realtime, m_data.out_channel, m_data.position,
                                 m_data.step_index, m_data.last);
                end else begin
                    want = ramp_expect.pop_front();
                    if (m_data.out_channel !== want.out_channel
                        || m_data.position !== want.position
                        || m_data.step_index !== want.step_index
                        || m_data.last !== want.last) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $write("%0t: mismatch exp ch=%0d pos=%0d idx=%0d last=%0b",
                                   $realtime, want.out_channel, want.position,
                                   want.step_index, want.last);
                            $display(" got ch=%0d pos=%0d idx=%0d last=%0b",
                                     m_data.out_channel, m_data.position,
                                     m_data.step_index, m_data.last);
                        end
                    end
                end
            end
            // back-pressure in bursts, none once the calm tail starts
            if (hold_gap > 0) begin
                hold_gap <= hold_gap - 1;
                m_ready  <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                hold_gap <= $urandom_range(0, 8);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : main_proc
        int counted;
        int kind;
        int ch;
        int val;
        int trm;
        bit drained_mid;
        counted     = 0;
        drained_mid = 1'b0;

        // directed: clamp edges, full swings, no-motion moves, bad channels
        void'(queue_req(CMD_SET,  0,   0,    0));
        void'(queue_req(CMD_MOVE, 0,   250,  0));     // full swing up
        void'(queue_req(CMD_MOVE, 0,   255,  127));   // clamps high onto current: no motion
        void'(queue_req(CMD_MOVE, 0,   0,    -128));  // clamps low, full swing down
        void'(queue_req(CMD_MOVE, 0,   200,  100));   // sum past a byte still clamps high
        void'(queue_req(CMD_MOVE, 0,   10,   -20));   // negative sum clamps to zero
        void'(queue_req(CMD_SET,  23,  255,  -1));    // set keeps raw value, trim ignored
        void'(queue_req(CMD_MOVE, 23,  0,    0));     // down 255: remainder 5
        void'(queue_req(CMD_MOVE, 23,  7,    0));     // short move, all in the first step
        void'(queue_req(CMD_MOVE, 23,  7,    0));     // same target again
        void'(queue_req(CMD_MOVE, 24,  100,  0));     // first channel past the bank
        void'(queue_req(CMD_SET,  31,  255,  -128));  // top channel code, ignored
        void'(queue_req(CMD_SET,  16,  170,  127));
        void'(queue_req(CMD_MOVE, 16,  85,   -1));
        void'(queue_req(CMD_MOVE, 16,  93,   0));     // up by less than one ramp
        void'(queue_req(CMD_MOVE, 15,  250,  127));
        void'(queue_req(CMD_MOVE, 8,   0,    0));     // fresh channel already at zero
        void'(queue_req(CMD_SET,  5,   1,    0));
        void'(queue_req(CMD_MOVE, 5,   0,    0));     // down by one
        void'(queue_req(CMD_MOVE, 5,   101,  -1));    // exact multiple, no remainder
        drain_next = 1'b1;

        // random part: plain moves, set-then-nudge pairs, lone sets, repeats, bad channels, extreme targets
        while (counted < 210) begin
            if (counted >= 175) gen_calm = 1'b1;
            if (counted >= 100 && !drained_mid) begin
                drain_next  = 1'b1;
                drained_mid = 1'b1;
            end
            kind = $urandom_range(0, 9);
            ch   = $urandom_range(0, CHANNELS_DEF - 1);
            val  = $urandom_range(0, 255);
            trm  = rand_trim();
            case (kind)
                0, 1, 2, 3: begin
                    counted += queue_req(CMD_MOVE, ch, val, trm);
                end
                4, 5: begin
                    // known start, then a small move around it
                    counted += queue_req(CMD_SET, ch, val, trm);
                    counted += queue_req(CMD_MOVE, ch, val, $urandom_range(0, 24) - 12);
                end
                6: begin
                    counted += queue_req(CMD_SET, ch, val, trm);
                end
                7: begin
                    counted += queue_req(CMD_MOVE, ch, val, trm);
                    counted += queue_req(CMD_MOVE, ch, val, trm);
                end
                8: begin
                    // out-of-range channel, either command
                    void'(queue_req(logic'($urandom_range(0, 1)),
                                    $urandom_range(CHANNELS_DEF, 31), val, trm));
                end
                default: begin
                    counted += queue_req(CMD_MOVE, ch, $urandom_range(0, 1) ? 0 : 255, trm);
                end
            endcase
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_backlog.size() != 0 || s_valid) @(posedge aclk);
        while (ramp_expect.size() != 0) @(posedge aclk);
        // catch any stray results after the last expected one
        repeat (20) @(posedge aclk);

        if (fault_count == 0 && ramp_expect.size() == 0) begin
            $display("servo_ramp_interpolator_tb: done, clean");
        end else begin
            $display("servo_ramp_interpolator_tb: done, errors");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2000000;
        $display("servo_ramp_interpolator_tb: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/srp_pkg.sv
rtl/srp_pos_store.sv
rtl/srp_ramp_calc.sv
rtl/srp_ramp_seq.sv
rtl/servo_ramp_interpolator.sv
rtl/srp_checker.sv
test/servo_ramp_interpolator_tb.sv
